[rtl/core/scgf_pkg.sv]
// Shared types and constants for the clause-count / greedy-flip block.
// Used by the front end, command queue, back end and top level.
package scgf_pkg;

   localparam int KIND_W      = 2;
   localparam int INDEX_W     = 10;
   localparam int WORD_W      = 64;
   localparam int COUNT_W     = 11;
   localparam int NVAR_W      = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EVAL   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GREEDY = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_VARIABLES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_CLAUSES   = 2'd1;

   localparam logic [NVAR_W-1:0]  NUM_VARIABLES_RESET = 7'd64;
   localparam logic [COUNT_W-1:0] NUM_CLAUSES_RESET   = 11'd0;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_EVAL,
      OP_GREEDY
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_JUDGE
   } state_type;

   // data_a carries the positive mask for a load, the assignment otherwise
   typedef struct packed {
      op_type              op;
      logic [INDEX_W-1:0]  addr;
      logic [WORD_W-1:0]   data_a;
      logic [WORD_W-1:0]   data_b;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_entry_type;

endpackage

[rtl/core/sat_clause_count_greedy_flip.sv]
// MaxSAT clause table with clause counting and a greedy bit-flip pass.
// Instantiates scgf_front, scgf_queue, scgf_back and scgf_ram; uses scgf_pkg.
//
// Request channel: a transaction is taken when start is high and busy is low.
// req_kind selects a clause load, an evaluate or a greedy flip pass. Commands
// go through a two-entry queue, so busy rises only when that queue is full.
// Loads give no response; an unused kind, or a load to a slot at or above
// MAX_CLAUSES, is dropped.
// Response channel: rsp_valid is high for one cycle with the count, the
// all-satisfied flag and the final assignment. The receiver cannot stall it.
// Passes: each pass reads the clause RAM once per clause (nc = effective
// clause count) through its single read port. Evaluate gives one pass,
// greedy gives nv + 1 passes (nv = effective variable count).
// One command runs at a time in the back end.
// Configuration: csr_valid/csr_ready write num_variables (index 0) and
// num_clauses (index 1); csr_ready is always high. Write only while idle.
// Reset clears the queue, the sequencer and the registers (64 variables,
// no clauses). The clause RAM is not cleared: load a slot before using it.
module sat_clause_count_greedy_flip #(
   parameter int MAX_VARIABLES = 64,
   parameter int MAX_CLAUSES   = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [scgf_pkg::KIND_W-1:0]      req_kind,
   input  logic [scgf_pkg::INDEX_W-1:0]     req_clause_index,
   input  logic [scgf_pkg::WORD_W-1:0]      req_positive_mask,
   input  logic [scgf_pkg::WORD_W-1:0]      req_negative_mask,
   input  logic [scgf_pkg::WORD_W-1:0]      req_assignment,
   output logic                             rsp_valid,
   output logic [scgf_pkg::COUNT_W-1:0]     rsp_satisfied_count,
   output logic                             rsp_all_satisfied,
   output logic [scgf_pkg::WORD_W-1:0]      rsp_final_assignment,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [scgf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [scgf_pkg::CSR_DATA_W-1:0]  csr_data
);
   import scgf_pkg::*;

   localparam int AW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;

   logic [NVAR_W-1:0]    num_variables_ff, num_variables_in;
   logic [COUNT_W-1:0]   num_clauses_ff, num_clauses_in;
   logic [NVAR_W-1:0]    nv;
   logic [COUNT_W-1:0]   nc;
   q_entry_type          push;
   q_entry_type          head;
   logic                 pop;
   logic                 full;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [2*WORD_W-1:0]  ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [2*WORD_W-1:0]  ram_rd_data;

   assign csr_ready = 1'b1;
   assign busy      = full;

   always_comb begin
      num_variables_in = num_variables_ff;
      num_clauses_in   = num_clauses_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_VARIABLES: num_variables_in = csr_data[NVAR_W-1:0];
            CSR_NUM_CLAUSES:   num_clauses_in   = csr_data[COUNT_W-1:0];
            default:           num_clauses_in   = num_clauses_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_variables_ff <= NUM_VARIABLES_RESET;
         num_clauses_ff   <= NUM_CLAUSES_RESET;
      end else begin
         num_variables_ff <= num_variables_in;
         num_clauses_ff   <= num_clauses_in;
      end
   end

   // saturate to the built-in table and word sizes
   assign nv = (32'(num_variables_ff) > MAX_VARIABLES) ? NVAR_W'(MAX_VARIABLES)
                                                       : num_variables_ff;
   assign nc = (32'(num_clauses_ff) > MAX_CLAUSES) ? COUNT_W'(MAX_CLAUSES)
                                                   : num_clauses_ff;

   scgf_front #(
      .MAX_CLAUSES (MAX_CLAUSES)
   ) u_front (
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_clause_index  (req_clause_index),
      .req_positive_mask (req_positive_mask),
      .req_negative_mask (req_negative_mask),
      .req_assignment    (req_assignment),
      .push              (push)
   );

   scgf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   scgf_back #(
      .MAX_CLAUSES (MAX_CLAUSES)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .pop                  (pop),
      .nv                   (nv),
      .nc                   (nc),
      .ram_wr_en            (ram_wr_en),
      .ram_wr_addr          (ram_wr_addr),
      .ram_wr_data          (ram_wr_data),
      .ram_rd_en            (ram_rd_en),
      .ram_rd_addr          (ram_rd_addr),
      .ram_rd_data          (ram_rd_data),
      .rsp_valid            (rsp_valid),
      .rsp_satisfied_count  (rsp_satisfied_count),
      .rsp_all_satisfied    (rsp_all_satisfied),
      .rsp_final_assignment (rsp_final_assignment)
   );

   scgf_ram #(
      .WIDTH (2 * WORD_W),
      .DEPTH (MAX_CLAUSES)
   ) u_clause_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

[rtl/core/scgf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scgf_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/scgf_front.sv]
// Front end: accepts request transactions and turns them into queue commands.
// Depends on scgf_pkg.
module scgf_front #(
   parameter int MAX_CLAUSES = 1024
) (
   input  logic                         start,
   input  logic                         busy,
   input  logic [scgf_pkg::KIND_W-1:0]  req_kind,
   input  logic [scgf_pkg::INDEX_W-1:0] req_clause_index,
   input  logic [scgf_pkg::WORD_W-1:0]  req_positive_mask,
   input  logic [scgf_pkg::WORD_W-1:0]  req_negative_mask,
   input  logic [scgf_pkg::WORD_W-1:0]  req_assignment,
   output scgf_pkg::q_entry_type        push
);
   import scgf_pkg::*;

   logic accept;
   logic slot_ok;

   assign accept  = start && !busy;
   assign slot_ok = 32'(req_clause_index) < MAX_CLAUSES;

   always_comb begin
      push            = '0;
      push.cmd.addr   = req_clause_index;
      push.cmd.data_a = req_assignment;
      push.cmd.data_b = req_negative_mask;
      case (req_kind)
         KIND_LOAD: begin
            push.valid      = accept && slot_ok;
            push.cmd.op     = OP_LOAD;
            push.cmd.data_a = req_positive_mask;
         end
         KIND_EVAL: begin
            push.valid  = accept;
            push.cmd.op = OP_EVAL;
         end
         KIND_GREEDY: begin
            push.valid  = accept;
            push.cmd.op = OP_GREEDY;
         end
         default: begin
            // unused kind: drop the transaction
            push.valid  = 1'b0;
            push.cmd.op = OP_EVAL;
         end
      endcase
   end

endmodule

[rtl/core/scgf_queue.sv]
// Short command FIFO between the front end and the back end.
// Depends on scgf_pkg.
module scgf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  scgf_pkg::q_entry_type push,
   input  logic                  pop,
   output scgf_pkg::q_entry_type head,
   output logic                  full
);
   import scgf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.cmd   = entries_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not follow a push");

endmodule

[rtl/core/scgf_back.sv]
// Back end: executes queued commands. Loads write the clause RAM; evaluate and
// greedy commands sweep the RAM once per trial assignment. Depends on scgf_pkg.
module scgf_back #(
   parameter int MAX_CLAUSES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  scgf_pkg::q_entry_type                head,
   output logic                                 pop,
   input  logic [scgf_pkg::NVAR_W-1:0]          nv,
   input  logic [scgf_pkg::COUNT_W-1:0]         nc,
   output logic                                 ram_wr_en,
   output logic [((MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1)-1:0] ram_wr_addr,
   output logic [2*scgf_pkg::WORD_W-1:0]        ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [((MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1)-1:0] ram_rd_addr,
   input  logic [2*scgf_pkg::WORD_W-1:0]        ram_rd_data,
   output logic                                 rsp_valid,
   output logic [scgf_pkg::COUNT_W-1:0]         rsp_satisfied_count,
   output logic                                 rsp_all_satisfied,
   output logic [scgf_pkg::WORD_W-1:0]          rsp_final_assignment
);
   import scgf_pkg::*;

   localparam int AW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
   localparam int CW = $clog2(MAX_CLAUSES + 1);
   localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

   state_type           state_ff, state_in;
   logic [CW-1:0]       issue_ff, issue_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [COUNT_W-1:0]  best_ff, best_in;
   logic [WORD_W-1:0]   a_ff, a_in;
   logic [WORD_W-1:0]   trial_ff, trial_in;
   logic [NVAR_W-1:0]   var_ff, var_in;
   logic                first_ff, first_in;
   logic                greedy_ff, greedy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_all_ff, rsp_all_in;
   logic [WORD_W-1:0]   rsp_assign_ff, rsp_assign_in;

   logic [WORD_W-1:0]   var_mask;
   logic [WORD_W-1:0]   hit_bits;
   logic                issue_more;
   logic                improve;
   logic [COUNT_W-1:0]  best_new;
   logic [WORD_W-1:0]   a_new;

   assign var_mask   = nv[NVAR_W-1] ? '1 : ((WORD_W'(1) << nv[NVAR_W-2:0]) - WORD_W'(1));
   assign hit_bits   = ((ram_rd_data[2*WORD_W-1:WORD_W] & trial_ff)
                     | (ram_rd_data[WORD_W-1:0] & ~trial_ff)) & var_mask;
   assign issue_more = NW'(issue_ff) < NW'(nc);
   assign improve    = !first_ff && (cnt_ff > best_ff);
   assign best_new   = (first_ff || improve) ? cnt_ff : best_ff;
   assign a_new      = improve ? trial_ff : a_ff;

   assign ram_wr_addr = AW'(head.cmd.addr);
   assign ram_wr_data = {head.cmd.data_a, head.cmd.data_b};
   assign ram_rd_addr = issue_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         cnt_ff       <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         cnt_ff       <= cnt_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff          <= a_in;
      trial_ff      <= trial_in;
      var_ff        <= var_in;
      first_ff      <= first_in;
      greedy_ff     <= greedy_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_all_ff    <= rsp_all_in;
      rsp_assign_ff <= rsp_assign_in;
   end

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      rd_valid_in   = 1'b0;
      cnt_in        = cnt_ff;
      best_in       = best_ff;
      a_in          = a_ff;
      trial_in      = trial_ff;
      var_in        = var_ff;
      first_in      = first_ff;
      greedy_in     = greedy_ff;
      rsp_valid_in  = 1'b0;
      rsp_count_in  = rsp_count_ff;
      rsp_all_in    = rsp_all_ff;
      rsp_assign_in = rsp_assign_ff;
      pop           = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.cmd.op)
                  OP_LOAD: begin
                     ram_wr_en = 1'b1;
                  end
                  OP_EVAL, OP_GREEDY: begin
                     a_in      = head.cmd.data_a;
                     trial_in  = head.cmd.data_a;
                     greedy_in = head.cmd.op == OP_GREEDY;
                     var_in    = '0;
                     first_in  = 1'b1;
                     issue_in  = '0;
                     cnt_in    = '0;
                     best_in   = '0;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                     ram_wr_en = 1'b0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue one clause read per cycle, count the one returned
            if (issue_more) begin
               ram_rd_en   = 1'b1;
               rd_valid_in = 1'b1;
               issue_in    = issue_ff + CW'(1);
            end
            if (rd_valid_ff && (hit_bits != '0)) begin
               cnt_in = cnt_ff + COUNT_W'(1);
            end
            if (!issue_more && !rd_valid_ff) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            best_in  = best_new;
            a_in     = a_new;
            first_in = 1'b0;
            if (!greedy_ff || (var_ff >= nv)) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = best_new;
               rsp_all_in    = best_new == nc;
               rsp_assign_in = a_new;
               state_in      = ST_IDLE;
            end else begin
               // next trial flips one more variable of the kept assignment
               trial_in = a_new ^ (WORD_W'(1) << var_ff[NVAR_W-2:0]);
               var_in   = var_ff + NVAR_W'(1);
               issue_in = '0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_satisfied_count  = rsp_count_ff;
   assign rsp_all_satisfied    = rsp_all_ff;
   assign rsp_final_assignment = rsp_assign_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_JUDGE))
      else $error("result strobe without a finished pass");

   assert property (@(posedge clock) disable iff (reset)
      NW'(cnt_ff) <= NW'(issue_ff))
      else $error("clause count ran ahead of issued reads");

   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN))
      else $error("read data returned outside a sweep");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff != ST_IDLE) && ($past(state_ff) != ST_IDLE)) |-> (best_ff >= $past(best_ff)))
      else $error("best count dropped during a command");

endmodule
